// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [7:0] MsbMask = 8'h80;
  localparam logic [7:0] ProbeAddrMask = 8'hFE;
  localparam logic [2:0] LastBit = 3'(BitsPerByte - 1);
  localparam int unsigned DelayW = 16;
  localparam logic [DelayW-1:0] DelayReset = 16'd144;

  // Command codes as they arrive on func_i.
  typedef enum logic [2:0] {
    FUNC_NONE      = 3'd0,
    FUNC_START     = 3'd1,
    FUNC_STOP      = 3'd2,
    FUNC_WRITE     = 3'd3,
    FUNC_READ_ACK  = 3'd4,
    FUNC_READ_NACK = 3'd5,
    FUNC_PROBE     = 3'd6
  } func_e;

  // One classified tick, passed from the front end to the engine.
  typedef struct packed {
    func_e       func;
    logic [7:0]  tx;
    logic        sda;
  } item_t;

endpackage

// ===== design/i2cm_front.sv =====
// Front end: accepts ticks, classifies the command and registers the item.
`timescale 1ns / 1ps

module i2cm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      func_i,
  input  logic [7:0]      tx_data_i,
  input  logic            sda_in_i,
  output logic            item_valid_o,
  output i2cm_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import i2cm_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  func_e func_dec;
  logic  take;

  always_comb begin
    unique case (func_i)
      FUNC_START, FUNC_STOP, FUNC_WRITE, FUNC_READ_ACK, FUNC_READ_NACK, FUNC_PROBE:
        func_dec = func_e'(func_i);
      default: func_dec = FUNC_NONE;
    endcase
  end

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d     = 1'b1;
      item_d.func = func_dec;
      item_d.tx   = (func_dec == FUNC_PROBE) ? (tx_data_i & ProbeAddrMask) : tx_data_i;
      item_d.sda  = sda_in_i;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/i2cm_queue.sv =====
// Short queue between the front end and the bus engine.
`timescale 1ns / 1ps

module i2cm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  i2cm_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output i2cm_pkg::item_t rd_item_o
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) count_d = count_q + 1'b1;
    else if (pop && !push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_item_i;
  end

endmodule

// ===== design/i2cm_engine.sv =====
// Bus engine: phase sequencer for SCL/SDA, result register toward the receiver.
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  i2cm_pkg::item_t             item_i,
  input  logic [i2cm_pkg::DelayW-1:0] delay_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        scl_out_o,
  output logic                        sda_out_o,
  output logic                        busy_res_o,
  output logic                        done_res_o,
  output logic [7:0]                  rx_byte_o,
  output logic                        no_ack_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_WA, PH_WB, PH_WC, PH_KA0,
    PH_KA1, PH_KA2, PH_RH, PH_RL, PH_AK0, PH_AK1, PH_AK2, PH_SP0
  } phase_e;

  phase_e            phase_q, phase_d, nxt;
  func_e             cmd_q, cmd_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [DelayW-1:0] tick_q, tick_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d, sda_q, sda_d;
  logic [7:0]        rx_q, rx_d;
  logic              done_q, done_d;
  logic              ovalid_q, ovalid_d;
  logic              pop, enter, finish;
  logic [DelayW-1:0] delay_eff;
  logic [DelayW:0]   tick_inc;

  assign item_ready_o = !ovalid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign delay_eff    = (delay_ticks_i == '0) ? DelayW'(1) : delay_ticks_i;
  assign tick_inc     = {1'b0, tick_q} + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    tick_d   = tick_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    done_d   = done_q;
    ovalid_d = ovalid_q;
    nxt      = PH_IDLE;
    enter    = 1'b0;
    finish   = 1'b0;

    if (pop) begin
      ovalid_d = 1'b1;
      done_d   = 1'b0;
      if (phase_q == PH_IDLE) begin
        if (item_i.func != FUNC_NONE) begin
          cmd_d = item_i.func;
          bit_d = '0;
          enter = 1'b1;
          unique case (item_i.func)
            FUNC_START: nxt = PH_ST0;
            FUNC_STOP:  nxt = PH_SP0;
            FUNC_WRITE: begin
              shift_d = item_i.tx;
              nxt     = PH_WA;
            end
            FUNC_READ_ACK, FUNC_READ_NACK: begin
              shift_d = '0;
              nxt     = PH_RH;
            end
            FUNC_PROBE: begin
              shift_d = item_i.tx;
              nxt     = PH_ST0;
            end
            default: enter = 1'b0;
          endcase
        end
      end else if (tick_inc < {1'b0, delay_eff}) begin
        tick_d = tick_inc[DelayW-1:0];
      end else begin
        enter = 1'b1;
        unique case (phase_q)
          PH_ST0: nxt = PH_ST1;
          PH_ST1: nxt = PH_ST2;
          PH_ST2: begin
            if (cmd_q == FUNC_PROBE) begin
              bit_d = '0;
              nxt   = PH_WA;
            end else begin
              finish = 1'b1;
            end
          end
          PH_WA: nxt = PH_WB;
          PH_WB: nxt = PH_WC;
          PH_WC: begin
            shift_d = {shift_q[6:0], 1'b0};
            if (bit_q != LastBit) begin
              bit_d = bit_q + 1'b1;
              nxt   = PH_WA;
            end else begin
              nxt = PH_KA0;
            end
          end
          PH_KA0: nxt = PH_KA1;
          PH_KA1: begin
            ack_d = item_i.sda;
            nxt   = PH_KA2;
          end
          PH_KA2: begin
            if (cmd_q == FUNC_PROBE) nxt = PH_SP0;
            else finish = 1'b1;
          end
          PH_RH: begin
            shift_d = {shift_q[6:0], item_i.sda};
            nxt     = PH_RL;
          end
          PH_RL: begin
            if (bit_q != LastBit) begin
              bit_d = bit_q + 1'b1;
              nxt   = PH_RH;
            end else begin
              nxt = PH_AK0;
            end
          end
          PH_AK0: nxt = PH_AK1;
          PH_AK1: nxt = PH_AK2;
          PH_AK2: begin
            rx_d   = shift_q;
            sda_d  = 1'b1;
            finish = 1'b1;
          end
          PH_SP0: begin
            sda_d  = 1'b1;
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
        if (finish) enter = 1'b0;
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    if (finish) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
      bit_d   = '0;
      cmd_d   = FUNC_NONE;
      done_d  = 1'b1;
    end

    if (enter) begin
      phase_d = nxt;
      tick_d  = '0;
      unique case (nxt)
        PH_ST0: begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_ST1: begin scl_d = 1'b1; sda_d = 1'b0; end
        PH_ST2: begin scl_d = 1'b0; sda_d = 1'b0; end
        PH_WA:  begin scl_d = 1'b0; sda_d = ((shift_d & MsbMask) != '0); end
        PH_WB:  scl_d = 1'b1;
        PH_WC: begin
          scl_d = 1'b0;
          if (bit_d == LastBit) sda_d = 1'b1;
        end
        PH_KA0: begin scl_d = 1'b0; sda_d = 1'b1; end
        PH_KA1: begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_KA2: begin scl_d = 1'b0; sda_d = 1'b1; end
        PH_RH:  begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_RL:  begin scl_d = 1'b0; sda_d = 1'b1; end
        PH_AK0: begin scl_d = 1'b0; sda_d = (cmd_d != FUNC_READ_ACK); end
        PH_AK1: scl_d = 1'b1;
        PH_AK2: scl_d = 1'b0;
        PH_SP0: begin scl_d = 1'b1; sda_d = 1'b0; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cmd_q    <= FUNC_NONE;
      bit_q    <= '0;
      shift_q  <= '0;
      tick_q   <= '0;
      ack_q    <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      rx_q     <= '0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      tick_q   <= tick_d;
      ack_q    <= ack_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      rx_q     <= rx_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = (phase_q != PH_IDLE);
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_q;
  assign no_ack_o    = ack_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == PH_IDLE)
    else $error("done raised while a command is still running");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> cmd_q != FUNC_NONE)
    else $error("sequencer busy without an active command");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> $stable(phase_q) && $stable(tick_q) && $stable(scl_q))
    else $error("engine advanced while its result was stalled");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0 && bit_q == '0)
    else $error("idle engine holds a stale counter");

endmodule

// ===== design/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer: top level with configuration register and front/back split.
//
// Usage: every transaction on the input channel (in_valid_i/in_ready_o) is one bus
// tick carrying func_i, tx_data_i and the sampled SDA level sda_in_i. Every tick
// produces exactly one result transaction on the output channel
// (out_valid_o/out_ready_i) with the SCL/SDA drive levels, busy, done, the last
// read byte and the last ACK sample. Commands arriving while busy are ignored.
// An input transaction passes through the front register, the queue and the engine
// register before its result appears; throughput is one tick per cycle while the
// receiver does not stall. A front register and a QueueDepth-entry queue decouple
// input from the engine, so input keeps flowing while a result waits.
// When the receiver stalls, the engine holds its state and result; the queue
// fills and then in_ready_o drops.
// Reset: lines released, engine idle, delay_ticks back to 144, queue empty. delay_ticks
// sits at APB address 0; the user must write it only while idle (not enforced).
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  tx_data_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        no_ack_o
);
  import i2cm_pkg::*;

  logic [DelayW-1:0] delay_q;
  logic              cfg_wr;
  logic              fe_valid, fe_ready, q_valid, q_ready;
  item_t             fe_item, q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-DelayW){1'b0}}, delay_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_wr) begin
      delay_q <= pwdata[DelayW-1:0];
    end
  end

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .tx_data_i    (tx_data_i),
    .sda_in_i     (sda_in_i),
    .item_valid_o (fe_valid),
    .item_o       (fe_item),
    .item_ready_i (fe_ready)
  );

  i2cm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_item_i  (fe_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_i        (q_item),
    .delay_ticks_i (delay_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_out_o     (scl_out_o),
    .sda_out_o     (sda_out_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .no_ack_o      (no_ack_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the I2C master bit sequencer: random command streams checked tick by tick.
`timescale 1ns / 1ps

module tb_top;
  import i2cm_pkg::*;

  localparam logic [2:0] ADDR_DELAY = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam logic [2:0] FUNC_SPARE = 3'd7;
  localparam int unsigned StartPhases = 3;
  localparam int unsigned WritePhases = 3 * BitsPerByte + 3;
  localparam int unsigned ReadPhases = 2 * BitsPerByte + 3;
  localparam int unsigned ProbePhases = StartPhases + WritePhases + 1;
  localparam int unsigned LIMIT = 40_000;
  localparam int unsigned SHOWN_ERRORS = 40;

  typedef enum logic [4:0] {
    S_IDLE, S_START_REL, S_START_SDA, S_START_LOW,
    S_BIT_SETUP, S_BIT_HIGH, S_BIT_HOLD,
    S_ACK_SETUP, S_ACK_HIGH, S_ACK_HOLD,
    S_RD_HIGH, S_RD_LOW,
    S_MACK_SETUP, S_MACK_HIGH, S_MACK_HOLD,
    S_STOP
  } bus_phase_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx;
    logic       sda;
  } bus_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       no_ack;
  } line_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [7:0]  tx_data_i = '0;
  logic        sda_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        no_ack_o;

  // model of the engine
  bus_phase_e  bus_phase = S_IDLE;
  func_e       cur_cmd = FUNC_NONE;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] tick_cnt = '0;
  logic        ack_bit = 1'b0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        done_q = 1'b0;
  logic [7:0]  rx_q = '0;
  logic [15:0] phase_ticks = DelayReset;

  bus_tick_t   tick_q[$];
  line_state_t outcome_q[$];
  bus_tick_t   nxt_tick;
  line_state_t want;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 56;
  int unsigned err_count = 0;
  int unsigned result_cnt = 0;
  int unsigned cycle_cnt = 0;

  i2c_master_bit_sequencer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .tx_data_i  (tx_data_i),
    .sda_in_i   (sda_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .scl_out_o  (scl_out_o),
    .sda_out_o  (sda_out_o),
    .busy_res_o (busy_res_o),
    .done_res_o (done_res_o),
    .rx_byte_o  (rx_byte_o),
    .no_ack_o   (no_ack_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void goto_phase(input bus_phase_e p);
    bus_phase = p;
    tick_cnt = '0;
    case (p)
      S_START_REL: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      S_START_SDA, S_STOP: begin
        scl_q = 1'b1;
        sda_q = 1'b0;
      end
      S_START_LOW: begin
        scl_q = 1'b0;
        sda_q = 1'b0;
      end
      S_BIT_SETUP: begin
        scl_q = 1'b0;
        sda_q = |(shreg & MsbMask);
      end
      S_BIT_HIGH, S_MACK_HIGH: scl_q = 1'b1;
      S_BIT_HOLD: begin
        scl_q = 1'b0;
        if (bit_cnt == 4'(LastBit)) sda_q = 1'b1;
      end
      S_ACK_SETUP, S_ACK_HOLD, S_RD_LOW: begin
        scl_q = 1'b0;
        sda_q = 1'b1;
      end
      S_ACK_HIGH, S_RD_HIGH: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
      end
      S_MACK_SETUP: begin
        scl_q = 1'b0;
        sda_q = (cur_cmd == FUNC_READ_ACK) ? 1'b0 : 1'b1;
      end
      S_MACK_HOLD: scl_q = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void end_command();
    bus_phase = S_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    cur_cmd = FUNC_NONE;
    done_q = 1'b1;
  endfunction

  // one bus tick through the engine model, returns the lines after the update
  function automatic line_state_t next_lines(input logic [2:0] f, input logic [7:0] tx,
                                             input logic sda);
    logic [16:0] span;
    span = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
    done_q = 1'b0;
    if (bus_phase == S_IDLE) begin
      if (f >= FUNC_START && f <= FUNC_PROBE) begin
        cur_cmd = func_e'(f);
        bit_cnt = '0;
        case (cur_cmd)
          FUNC_START: goto_phase(S_START_REL);
          FUNC_STOP: goto_phase(S_STOP);
          FUNC_WRITE: begin
            shreg = tx;
            goto_phase(S_BIT_SETUP);
          end
          FUNC_READ_ACK, FUNC_READ_NACK: begin
            shreg = '0;
            goto_phase(S_RD_HIGH);
          end
          default: begin
            shreg = tx & ProbeAddrMask;
            goto_phase(S_START_REL);
          end
        endcase
      end
    end else if ({1'b0, tick_cnt} + 17'd1 < span) begin
      tick_cnt = tick_cnt + 16'd1;
    end else begin
      case (bus_phase)
        S_START_REL: goto_phase(S_START_SDA);
        S_START_SDA: goto_phase(S_START_LOW);
        S_START_LOW: begin
          if (cur_cmd == FUNC_PROBE) begin
            bit_cnt = '0;
            goto_phase(S_BIT_SETUP);
          end else begin
            end_command();
          end
        end
        S_BIT_SETUP: goto_phase(S_BIT_HIGH);
        S_BIT_HIGH: goto_phase(S_BIT_HOLD);
        S_BIT_HOLD: begin
          shreg = shreg << 1;
          if (bit_cnt < 4'(LastBit)) begin
            bit_cnt = bit_cnt + 4'd1;
            goto_phase(S_BIT_SETUP);
          end else begin
            goto_phase(S_ACK_SETUP);
          end
        end
        S_ACK_SETUP: goto_phase(S_ACK_HIGH);
        S_ACK_HIGH: begin
          ack_bit = sda;
          goto_phase(S_ACK_HOLD);
        end
        S_ACK_HOLD: begin
          if (cur_cmd == FUNC_PROBE) goto_phase(S_STOP);
          else end_command();
        end
        S_RD_HIGH: begin
          shreg = {shreg[6:0], sda};
          goto_phase(S_RD_LOW);
        end
        S_RD_LOW: begin
          if (bit_cnt < 4'(LastBit)) begin
            bit_cnt = bit_cnt + 4'd1;
            goto_phase(S_RD_HIGH);
          end else begin
            goto_phase(S_MACK_SETUP);
          end
        end
        S_MACK_SETUP: goto_phase(S_MACK_HIGH);
        S_MACK_HIGH: goto_phase(S_MACK_HOLD);
        S_MACK_HOLD: begin
          rx_q = shreg;
          sda_q = 1'b1;
          end_command();
        end
        S_STOP: begin
          sda_q = 1'b1;
          end_command();
        end
        default: end_command();
      endcase
    end
    return '{scl: scl_q, sda: sda_q, busy: (bus_phase != S_IDLE), done: done_q,
             rx: rx_q, no_ack: ack_bit};
  endfunction

  task automatic report_error(input string msg);
    if (err_count < SHOWN_ERRORS) $display("mismatch at result %0d: %s", result_cnt, msg);
    err_count++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_tick = tick_q.pop_front();
        in_valid_i <= 1'b1;
        func_i <= nxt_tick.func;
        tx_data_i <= nxt_tick.tx;
        sda_in_i <= nxt_tick.sda;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) outcome_q.push_back(next_lines(func_i, tx_data_i, sda_in_i));
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_error("result with no transaction pending");
        end else begin
          want = outcome_q.pop_front();
          if (scl_out_o !== want.scl)
            report_error($sformatf("scl_out %b, expected %b", scl_out_o, want.scl));
          if (sda_out_o !== want.sda)
            report_error($sformatf("sda_out %b, expected %b", sda_out_o, want.sda));
          if (busy_res_o !== want.busy)
            report_error($sformatf("busy %b, expected %b", busy_res_o, want.busy));
          if (done_res_o !== want.done)
            report_error($sformatf("done %b, expected %b", done_res_o, want.done));
          if (rx_byte_o !== want.rx)
            report_error($sformatf("rx_byte %h, expected %h", rx_byte_o, want.rx));
          if (no_ack_o !== want.no_ack)
            report_error($sformatf("no_ack %b, expected %b", no_ack_o, want.no_ack));
        end
        result_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic wait_drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || outcome_q.size() != 0);
  endtask

  // run out the current command with no-op ticks
  task automatic settle();
    wait_drain();
    while (bus_phase != S_IDLE) begin
      repeat (16) tick_q.push_back('{func: FUNC_NONE, tx: 8'($urandom),
                                     sda: 1'($urandom_range(1))});
      wait_drain();
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
    settle();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_DELAY) phase_ticks = value;
  endtask

  // command tick plus enough busy ticks to finish it; trim cuts the tail short
  task automatic queue_command(input logic [2:0] f, input logic [7:0] tx, input int sda_fix,
                               input int trim);
    int span;
    int n;
    bus_tick_t t;
    span = (phase_ticks == '0) ? 1 : int'(phase_ticks);
    case (f)
      FUNC_START: n = StartPhases * span;
      FUNC_STOP: n = span;
      FUNC_WRITE: n = WritePhases * span;
      FUNC_READ_ACK, FUNC_READ_NACK: n = ReadPhases * span;
      FUNC_PROBE: n = ProbePhases * span;
      default: n = 0;
    endcase
    n = (n > trim) ? n - trim : 0;
    @(negedge clk_i);
    for (int i = 0; i <= n; i++) begin
      t.func = (i == 0) ? f : 3'($urandom_range(7));
      t.tx = (i == 0) ? tx : 8'($urandom);
      t.sda = (sda_fix < 0) ? 1'($urandom_range(1)) : 1'(sda_fix);
      tick_q.push_back(t);
    end
  endtask

  task automatic random_run(input int cmds);
    int r;
    for (int c = 0; c < cmds; c++) begin
      r = $urandom_range(99);
      if (r < 3) wait_drain();
      if (r < 10) begin
        queue_command((r < 5) ? 3'(FUNC_NONE) : FUNC_SPARE, 8'($urandom), -1, 0);
      end else begin
        queue_command(3'($urandom_range(int'(FUNC_PROBE), int'(FUNC_START))), 8'($urandom),
                      -1, (r >= 92) ? $urandom_range(40, 1) : 0);
      end
    end
  endtask

  initial begin
    int d;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_command(FUNC_STOP, 8'h00, -1, 0);
    apb_write(ADDR_DELAY, 16'd0);
    queue_command(FUNC_WRITE, 8'hFF, 0, 0);
    queue_command(FUNC_WRITE, 8'h00, 1, 0);
    queue_command(FUNC_READ_ACK, 8'h00, 1, 0);
    queue_command(FUNC_READ_NACK, 8'hFF, 0, 0);
    queue_command(FUNC_READ_ACK, 8'h3C, -1, 0);
    queue_command(FUNC_PROBE, 8'hFF, 0, 0);
    queue_command(FUNC_PROBE, 8'h00, 1, 0);
    queue_command(FUNC_SPARE, 8'hFF, -1, 0);
    queue_command(FUNC_NONE, 8'hFF, -1, 0);
    // write arrives while the start is still running
    queue_command(FUNC_START, 8'h00, -1, 2);
    queue_command(FUNC_WRITE, 8'hA5, -1, 0);
    apb_write(ADDR_SPARE, 16'd9);
    queue_command(FUNC_STOP, 8'h00, -1, 0);
    apb_write(ADDR_DELAY, 16'hFFFF);
    queue_command(FUNC_NONE, 8'h00, -1, 0);
    apb_write(ADDR_DELAY, 16'd1);
    queue_command(FUNC_WRITE, 8'h5A, -1, 0);

    for (int mode = 0; mode < 3; mode++) begin
      wait_drain();
      case (mode)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        d = ($urandom_range(7) == 0) ? $urandom_range(4, 3) : $urandom_range(1);
        apb_write(ADDR_DELAY, 16'(d));
        random_run(5);
      end
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_engine.sv
design/i2c_master_bit_sequencer_unit.sv
bench/tb_top.sv
